@@ rtl/core/mep_pkg.sv @@
// Shared package for the Mandelbrot escape-time pixel block.
// Holds word widths, register reset values, register codes, the controller
// command and status structs and the saturation helper. Depends on nothing.
package mep_pkg;

    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 64;
    localparam int STEP_BITS = 31;
    localparam int ITER_BITS = 8;
    localparam int CFG_INDEX_BITS = 3;

    localparam int DEF_COLUMN_BITS   = 11;
    localparam int DEF_ROW_BITS      = 10;
    localparam int DEF_FRACTION_BITS = 28;

    // Register codes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_REAL    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_IMAG    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_REAL      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_IMAG      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 3'd4;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] origin_real;
        logic signed [WORD_BITS-1:0] origin_imag;
        logic        [STEP_BITS-1:0] step_real;
        logic        [STEP_BITS-1:0] step_imag;
        logic        [ITER_BITS-1:0] max_iterations;
    } mep_cfg_t;

    // Reset view: -2.0, -1.0, 3/1400, 2/700 and 32 iterations.
    localparam mep_cfg_t CFG_RESET = '{
        origin_real:    32'shE000_0000,
        origin_imag:    32'shF000_0000,
        step_real:      31'd575219,
        step_imag:      31'd766958,
        max_iterations: 8'd32
    };

    typedef struct packed {
        logic load;      // capture the pixel coordinates
        logic map_mul;   // index times step on the multiplier set
        logic map_add;   // add origin, saturate, clear z
        logic iter_mul;  // square terms and cross term of z
        logic iter_upd;  // write the new z
        logic finish;    // register the result and strobe it
    } mep_cmd_t;

    typedef struct packed {
        logic escaped;
    } mep_stat_t;

    localparam logic signed [PROD_BITS-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_BITS-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [PROD_BITS-1:0] v
    );
        logic signed [WORD_BITS-1:0] r;
        priority if (v > SAT_HI)
        begin
            r = SAT_HI[WORD_BITS-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[WORD_BITS-1:0];
        end
        else
        begin
            r = v[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/mep_cfg.sv @@
// Configuration register file for the Mandelbrot escape-time pixel block.
// Depends on mep_pkg for the register codes, field widths and reset values.
module mep_cfg
    import mep_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data,
    output mep_cfg_t                  cfg
);

    mep_cfg_t cfg_reg;

    // Writes to an unused index are dropped; upper data bits are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_REAL:    cfg_reg.origin_real    <= $signed(cfg_data);
                REG_ORIGIN_IMAG:    cfg_reg.origin_imag    <= $signed(cfg_data);
                REG_STEP_REAL:      cfg_reg.step_real      <= cfg_data[STEP_BITS-1:0];
                REG_STEP_IMAG:      cfg_reg.step_imag      <= cfg_data[STEP_BITS-1:0];
                REG_MAX_ITERATIONS: cfg_reg.max_iterations <= cfg_data[ITER_BITS-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/mep_dpath.sv @@
// Datapath of the Mandelbrot escape-time pixel block: coordinate mapping,
// the shared set of three multipliers, z update with saturation and the
// escape compare. Depends on mep_pkg; driven by mep_ctrl commands.
module mep_dpath
    import mep_pkg::*;
#(
    parameter int COLUMN_BITS   = DEF_COLUMN_BITS,
    parameter int ROW_BITS      = DEF_ROW_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mep_cmd_t               cmd,
    output mep_stat_t              stat,
    input  mep_cfg_t               cfg,
    input  logic [COLUMN_BITS-1:0] column,
    input  logic [ROW_BITS-1:0]    row,
    output logic                   done,
    output logic [COLUMN_BITS-1:0] out_column,
    output logic [ROW_BITS-1:0]    out_row,
    output logic                   inside_set
);

    // |z|^2 > 4 compared on the full products, so the threshold is 2^(2F+2).
    localparam int  THRESH_SHIFT = 2 * FRACTION_BITS + 2;
    localparam bit  CAN_ESCAPE   = (THRESH_SHIFT < PROD_BITS);
    localparam logic [PROD_BITS-1:0] THRESH =
        CAN_ESCAPE ? (PROD_BITS'(1) << THRESH_SHIFT) : '0;

    logic [COLUMN_BITS-1:0]      col_reg;
    logic [ROW_BITS-1:0]         row_reg;
    logic signed [WORD_BITS-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [WORD_BITS-1:0] cre_reg, cim_reg, cre_next, cim_next;
    logic signed [PROD_BITS-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [PROD_BITS-1:0] pa_next, pb_next, pc_next;
    logic signed [WORD_BITS-1:0] ma_l, ma_r, mb_l, mb_r;
    logic signed [PROD_BITS-1:0] diff;
    logic        [PROD_BITS-1:0] mag_sum;
    logic [COLUMN_BITS-1:0]      out_column_reg;
    logic [ROW_BITS-1:0]         out_row_reg;
    logic                        inside_reg;
    logic                        done_reg;
    logic                        escaped;

    // Operand select: coordinate products while mapping, z terms otherwise.
    always_comb
    begin
        if (cmd.map_mul)
        begin
            ma_l = $signed({{(WORD_BITS-COLUMN_BITS){1'b0}}, col_reg});
            ma_r = $signed({1'b0, cfg.step_real});
            mb_l = $signed({{(WORD_BITS-ROW_BITS){1'b0}}, row_reg});
            mb_r = $signed({1'b0, cfg.step_imag});
        end
        else
        begin
            ma_l = x_reg;
            ma_r = x_reg;
            mb_l = y_reg;
            mb_r = y_reg;
        end
    end

    assign pa_next = PROD_BITS'(ma_l) * PROD_BITS'(ma_r);
    assign pb_next = PROD_BITS'(mb_l) * PROD_BITS'(mb_r);
    assign pc_next = PROD_BITS'(x_reg) * PROD_BITS'(y_reg);

    assign cre_next = sat_word(PROD_BITS'(cfg.origin_real) + pa_reg);
    assign cim_next = sat_word(PROD_BITS'(cfg.origin_imag) + pb_reg);

    // The arithmetic shifts give the floor of the scaled products.
    assign diff   = pa_reg - pb_reg;
    assign x_next = sat_word((diff >>> FRACTION_BITS) + PROD_BITS'(cre_reg));
    assign y_next = sat_word((pc_reg >>> (FRACTION_BITS - 1)) + PROD_BITS'(cim_reg));

    assign mag_sum = $unsigned(pa_reg) + $unsigned(pb_reg);
    assign escaped = CAN_ESCAPE && (mag_sum > THRESH);
    assign stat.escaped = escaped;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        if (cmd.map_mul || cmd.iter_mul)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
        if (cmd.map_add)
        begin
            cre_reg <= cre_next;
            cim_reg <= cim_next;
            x_reg   <= '0;
            y_reg   <= '0;
        end
        else if (cmd.iter_upd)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
        if (cmd.finish)
        begin
            out_column_reg <= col_reg;
            out_row_reg    <= row_reg;
            inside_reg     <= !escaped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign done       = done_reg;
    assign out_column = out_column_reg;
    assign out_row    = out_row_reg;
    assign inside_set = inside_reg;

endmodule

@@ rtl/core/mep_ctrl.sv @@
// Controller of the Mandelbrot escape-time pixel block: one-hot sequencer
// and iteration counter that steer mep_dpath. Depends on mep_pkg.
module mep_ctrl
    import mep_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ITER_BITS-1:0] max_iterations,
    input  mep_stat_t            stat,
    output mep_cmd_t             cmd
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_MAP_MUL  = 5'b00010,
        ST_MAP_ADD  = 5'b00100,
        ST_ITER_MUL = 5'b01000,
        ST_ITER_UPD = 5'b10000
    } mep_state_t;

    mep_state_t           state_reg, state_next;
    logic [ITER_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL:
            begin
                cmd.map_mul = 1'b1;
                state_next  = ST_MAP_ADD;
            end
            ST_MAP_ADD:
            begin
                cmd.map_add = 1'b1;
                cnt_next    = '0;
                state_next  = ST_ITER_MUL;
            end
            ST_ITER_MUL:
            begin
                cmd.iter_mul = 1'b1;
                state_next   = ST_ITER_UPD;
            end
            ST_ITER_UPD:
            begin
                // The products just formed belong to the latest z, so the
                // escape test for the previous iteration is made here.
                if (stat.escaped || (cnt_reg == max_iterations))
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.iter_upd = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    state_next   = ST_ITER_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("mep_ctrl: more than one datapath command at once");

    a_accept_maps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> (state_reg == ST_MAP_MUL))
        else $error("mep_ctrl: accepted item did not enter mapping");

    a_upd_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER_UPD) |=>
            (state_reg == ST_ITER_MUL || state_reg == ST_IDLE))
        else $error("mep_ctrl: bad successor of the update step");

endmodule

@@ rtl/core/mandelbrot_escape_pixel.sv @@
// Top level of the Mandelbrot escape-time pixel block.
// Depends on mep_pkg and instantiates mep_cfg, mep_ctrl and mep_dpath.
//
// Usage. A pixel item (column, row) is taken at a rising edge where start is
// high and busy is low. The block maps it to c = origin + index * step in
// signed fixed point, then iterates z = z*z + c from zero, stopping when
// |z|^2 exceeds 4 or after max_iterations iterations.
// The result item (out_column, out_row, inside_set) is shown for exactly one
// cycle with done high; the receiver cannot stall it, so it must take it then.
// Each iteration runs a multiply step on the shared set of three 32x32
// multipliers and then a step for the add, saturation and escape compare.
// Mapping uses the same multipliers in a multiply step and then an add step.
// done is registered from the stop decision, and the result item is taken at
// the edge that ends the cycle in which done is high. A new item may be
// accepted in the cycle in which done is high. Configuration: cfg_we with
// cfg_index and cfg_data writes one register at once; write only while busy is
// low. Reset loads the default view and leaves the block idle with done low.
module mandelbrot_escape_pixel
    import mep_pkg::*;
#(
    parameter int COLUMN_BITS   = DEF_COLUMN_BITS,
    parameter int ROW_BITS      = DEF_ROW_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [COLUMN_BITS-1:0]    column,
    input  logic [ROW_BITS-1:0]       row,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data,
    output logic                      done,
    output logic [COLUMN_BITS-1:0]    out_column,
    output logic [ROW_BITS-1:0]       out_row,
    output logic                      inside_set
);

    mep_cfg_t  cfg;
    mep_cmd_t  cmd;
    mep_stat_t stat;

    // Register file for the view and the iteration limit.
    mep_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: owns the state and the iteration count.
    mep_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .max_iterations (cfg.max_iterations),
        .stat           (stat),
        .cmd            (cmd)
    );

    // Arithmetic: mapping, multiplier set, z update and the output item.
    mep_dpath #(
        .COLUMN_BITS   (COLUMN_BITS),
        .ROW_BITS      (ROW_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg        (cfg),
        .column     (column),
        .row        (row),
        .done       (done),
        .out_column (out_column),
        .out_row    (out_row),
        .inside_set (inside_set)
    );

    // A result is only ever presented once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("mandelbrot_escape_pixel: result strobe while busy");

    // Each item yields a single one-cycle strobe.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("mandelbrot_escape_pixel: result strobe repeated");

endmodule
